@@ rtl/hjsps_pkg.sv @@
// Shared constants for the HTTP status / JSON string-pair scanner.
// Phase and event codes, string length limits and character constants.
// No dependencies.
package hjsps_pkg;

    localparam int MAX_STRING = 64;
    localparam int LEN_W      = 6;
    localparam int PHASE_W    = 4;
    localparam int EVENT_W    = 3;
    localparam int STATUS_W   = 10;
    localparam int SKIP_W     = 4;
    localparam int MUL_W      = 14;

    localparam logic [SKIP_W-1:0]   STATUS_SKIP = SKIP_W'(9);
    localparam logic [STATUS_W-1:0] STATUS_MAX  = STATUS_W'(999);

    localparam logic [PHASE_W-1:0] PH_HTTP    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_FIND    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_HAVE    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_INKEY   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HAVEKEY = 4'd4;
    localparam logic [PHASE_W-1:0] PH_INVAL   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_HAVEVAL = 4'd6;
    localparam logic [PHASE_W-1:0] PH_KEYLONG = 4'd7;
    localparam logic [PHASE_W-1:0] PH_VALLONG = 4'd8;

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_KEYCHAR  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_VALCHAR  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_KEYDONE  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_PAIRDONE = 3'd4;
    localparam logic [EVENT_W-1:0] EV_STATUS   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_KEYTRUNC = 3'd6;
    localparam logic [EVENT_W-1:0] EV_VALTRUNC = 3'd7;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

@@ rtl/http_json_string_pair_scanner_core.sv @@
// Top level of the HTTP status / JSON string-pair scanner.
// An accepted byte is registered in the input stage; its result is registered in the result stage.
// Throughput: one byte per cycle unless out_ready stalls; the parse state updates once per byte.
// Reset (rst_n low, asynchronous) clears both stages and returns the parser to the
// HTTP status phase; a restart command resets the parse state in-band and yields one result.
// Depends on hjsps_pkg.
module http_json_string_pair_scanner_core
    import hjsps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [EVENT_W-1:0]  event_res,
    output logic [7:0]          char_out,
    output logic [5:0]          char_position,
    output logic [PHASE_W-1:0]  parse_phase,
    output logic [STATUS_W-1:0] status_code
);

    logic                in_valid_reg;
    logic                cmd_reg;
    logic [7:0]          byte_reg;
    logic                out_valid_reg;
    logic [EVENT_W-1:0]  event_reg;
    logic [7:0]          char_reg;
    logic [5:0]          pos_reg;
    logic [PHASE_W-1:0]  phase_out_reg;
    logic [STATUS_W-1:0] status_out_reg;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                esc_reg, esc_next;
    logic [LEN_W-1:0]    key_len_reg, key_len_next;
    logic [LEN_W-1:0]    val_len_reg, val_len_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [EVENT_W-1:0]  ev_next;
    logic [7:0]          ch_next;
    logic [5:0]          pos_next;

    logic                advance;
    logic [PHASE_W-1:0]  ph;
    logic                is_digit;
    logic                is_sep;
    logic [MUL_W-1:0]    mac;
    logic [LEN_W+1:0]    len_plus2;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_sep   = (byte_reg == CH_LF) || (byte_reg == CH_SPACE) || (byte_reg == CH_TAB)
                   || (byte_reg == CH_CR) || (byte_reg == CH_COLON);
    assign mac      = MUL_W'(status_reg) * MUL_W'(10) + MUL_W'(byte_reg - CH_ZERO);
    assign ph       = (phase_reg == PH_HAVEVAL) ? PH_HAVE : phase_reg;
    assign len_plus2 = (phase_reg == PH_INKEY) ? ((LEN_W+2)'(key_len_reg) + (LEN_W+2)'(2))
                                               : ((LEN_W+2)'(val_len_reg) + (LEN_W+2)'(2));

    always_comb
    begin
        phase_next  = ph;
        esc_next    = esc_reg;
        key_len_next = key_len_reg;
        val_len_next = val_len_reg;
        skip_next   = skip_reg;
        status_next = status_reg;
        ev_next     = EV_NONE;
        ch_next     = 8'd0;
        pos_next    = 6'd0;
        if (cmd_reg)
        begin
            phase_next   = PH_HTTP;
            esc_next     = 1'b0;
            key_len_next = '0;
            val_len_next = '0;
            skip_next    = '0;
            status_next  = '0;
        end
        else
        begin
            case (ph)
                PH_HTTP:
                begin
                    if (skip_reg < STATUS_SKIP)
                    begin
                        skip_next = skip_reg + SKIP_W'(1);
                    end
                    else if (is_digit)
                    begin
                        status_next = (mac > MUL_W'(STATUS_MAX)) ? STATUS_MAX
                                                                 : mac[STATUS_W-1:0];
                    end
                    else
                    begin
                        phase_next = PH_FIND;
                        ev_next    = EV_STATUS;
                    end
                end
                PH_FIND:
                begin
                    if (byte_reg == CH_LBRACE)
                    begin
                        phase_next = PH_HAVE;
                    end
                end
                PH_HAVE:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        phase_next   = PH_INKEY;
                        key_len_next = '0;
                        val_len_next = '0;
                        esc_next     = 1'b0;
                    end
                end
                PH_INKEY, PH_INVAL:
                begin
                    if (!esc_reg && byte_reg == CH_QUOTE)
                    begin
                        phase_next = (ph == PH_INKEY) ? PH_HAVEKEY : PH_HAVEVAL;
                        ev_next    = (ph == PH_INKEY) ? EV_KEYDONE : EV_PAIRDONE;
                    end
                    else if (!esc_reg && byte_reg == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        ch_next  = byte_reg;
                        if (ph == PH_INKEY)
                        begin
                            ev_next      = EV_KEYCHAR;
                            pos_next     = key_len_reg;
                            key_len_next = key_len_reg + LEN_W'(1);
                            if (len_plus2 >= (LEN_W+2)'(MAX_STRING))
                            begin
                                phase_next = PH_KEYLONG;
                            end
                        end
                        else
                        begin
                            ev_next      = EV_VALCHAR;
                            pos_next     = val_len_reg;
                            val_len_next = val_len_reg + LEN_W'(1);
                            if (len_plus2 >= (LEN_W+2)'(MAX_STRING))
                            begin
                                phase_next = PH_VALLONG;
                            end
                        end
                    end
                end
                PH_HAVEKEY:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        phase_next = PH_INVAL;
                        esc_next   = 1'b0;
                    end
                    else if (!is_sep)
                    begin
                        phase_next = PH_HAVE;
                    end
                end
                PH_KEYLONG, PH_VALLONG:
                begin
                    if (!esc_reg && byte_reg == CH_QUOTE)
                    begin
                        phase_next = (ph == PH_KEYLONG) ? PH_HAVEKEY : PH_HAVEVAL;
                        ev_next    = (ph == PH_KEYLONG) ? EV_KEYTRUNC : EV_VALTRUNC;
                    end
                    else if (!esc_reg && byte_reg == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= command;
            byte_reg <= data_byte;
        end
    end

    // parse state, updated once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HTTP;
            esc_reg     <= 1'b0;
            key_len_reg <= '0;
            val_len_reg <= '0;
            skip_reg    <= '0;
            status_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            key_len_reg <= key_len_next;
            val_len_reg <= val_len_next;
            skip_reg    <= skip_next;
            status_reg  <= status_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg      <= ev_next;
            char_reg       <= ch_next;
            pos_reg        <= pos_next;
            phase_out_reg  <= phase_next;
            status_out_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign char_out      = char_reg;
    assign char_position = pos_reg;
    assign parse_phase   = phase_out_reg;
    assign status_code   = status_out_reg;

endmodule

@@ verif/hjsps_tb_pkg.sv @@
// Scoreboard for the HTTP status / JSON string-pair scanner testbench.
// Tracks the parse state byte by byte and checks each result against it.
// Depends on hjsps_pkg.
package hjsps_tb_pkg;
    import hjsps_pkg::*;

    typedef struct {
        logic [EVENT_W-1:0]  ev;
        logic [7:0]          ch;
        logic [5:0]          pos;
        logic [PHASE_W-1:0]  phase;
        logic [STATUS_W-1:0] status;
    } scan_event_t;

    class pair_scan_tracker;
        scan_event_t        expected_events[$];
        logic [PHASE_W-1:0] cur_phase;
        bit                 in_escape;
        int                 key_len;
        int                 val_len;
        int                 skip_cnt;
        int                 status_acc;
        int                 mismatches;
        int                 checked;
        int                 pairs_done;
        int                 truncations;
        int                 status_lines;
        int                 restarts;

        function new();
            clear_parse();
            mismatches   = 0;
            checked      = 0;
            pairs_done   = 0;
            truncations  = 0;
            status_lines = 0;
            restarts     = 0;
        endfunction

        function void clear_parse();
            cur_phase  = PH_HTTP;
            in_escape  = 1'b0;
            key_len    = 0;
            val_len    = 0;
            skip_cnt   = 0;
            status_acc = 0;
        endfunction

        function void absorb_byte(bit cmd, logic [7:0] c);
            scan_event_t e;
            bit          is_key;
            int          acc;
            e.ev  = EV_NONE;
            e.ch  = 8'h00;
            e.pos = 6'd0;
            if (cmd) begin
                clear_parse();
                restarts++;
            end
            else begin
                if (cur_phase == PH_HAVEVAL)
                    cur_phase = PH_HAVE;
                case (cur_phase)
                    PH_HTTP:
                    begin
                        if (skip_cnt < int'(STATUS_SKIP))
                            skip_cnt++;
                        else if (c >= CH_ZERO && c <= CH_NINE)
                        begin
                            acc = status_acc * 10 + int'(c - CH_ZERO);
                            status_acc = (acc > int'(STATUS_MAX)) ? int'(STATUS_MAX) : acc;
                        end
                        else
                        begin
                            cur_phase = PH_FIND;
                            e.ev = EV_STATUS;
                            status_lines++;
                        end
                    end
                    PH_FIND:
                    begin
                        if (c == CH_LBRACE)
                            cur_phase = PH_HAVE;
                    end
                    PH_HAVE:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            cur_phase = PH_INKEY;
                            key_len   = 0;
                            val_len   = 0;
                            in_escape = 1'b0;
                        end
                    end
                    PH_INKEY, PH_INVAL:
                    begin
                        is_key = (cur_phase == PH_INKEY);
                        if (!in_escape && c == CH_QUOTE)
                        begin
                            cur_phase = is_key ? PH_HAVEKEY : PH_HAVEVAL;
                            e.ev = is_key ? EV_KEYDONE : EV_PAIRDONE;
                            if (!is_key)
                                pairs_done++;
                        end
                        else if (!in_escape && c == CH_BSLASH)
                            in_escape = 1'b1;
                        else
                        begin
                            in_escape = 1'b0;
                            e.ch = c;
                            if (is_key)
                            begin
                                e.ev  = EV_KEYCHAR;
                                e.pos = key_len[5:0];
                                key_len++;
                                if (key_len + 1 >= MAX_STRING)
                                    cur_phase = PH_KEYLONG;
                            end
                            else
                            begin
                                e.ev  = EV_VALCHAR;
                                e.pos = val_len[5:0];
                                val_len++;
                                if (val_len + 1 >= MAX_STRING)
                                    cur_phase = PH_VALLONG;
                            end
                        end
                    end
                    PH_HAVEKEY:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            cur_phase = PH_INVAL;
                            in_escape = 1'b0;
                        end
                        else if (!(c == CH_LF || c == CH_SPACE || c == CH_TAB ||
                                   c == CH_CR || c == CH_COLON))
                            cur_phase = PH_HAVE;
                    end
                    PH_KEYLONG, PH_VALLONG:
                    begin
                        is_key = (cur_phase == PH_KEYLONG);
                        if (!in_escape && c == CH_QUOTE)
                        begin
                            cur_phase = is_key ? PH_HAVEKEY : PH_HAVEVAL;
                            e.ev = is_key ? EV_KEYTRUNC : EV_VALTRUNC;
                            truncations++;
                        end
                        else if (!in_escape && c == CH_BSLASH)
                            in_escape = 1'b1;
                        else
                            in_escape = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            e.phase  = cur_phase;
            e.status = status_acc[STATUS_W-1:0];
            expected_events.push_back(e);
        endfunction

        function void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (act_val !== exp_val)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            end
        endfunction

        function void compare_event(logic [EVENT_W-1:0] ev, logic [7:0] ch, logic [5:0] pos,
                                    logic [PHASE_W-1:0] ph, logic [STATUS_W-1:0] st);
            scan_event_t e;
            if (expected_events.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, event_res %0d", $time, ev);
                return;
            end
            e = expected_events.pop_front();
            checked++;
            check_field("event_res", 16'(e.ev), 16'(ev));
            check_field("char_out", 16'(e.ch), 16'(ch));
            check_field("char_position", 16'(e.pos), 16'(pos));
            check_field("parse_phase", 16'(e.phase), 16'(ph));
            check_field("status_code", 16'(e.status), 16'(st));
        endfunction
    endclass

endpackage

@@ verif/tb.sv @@
// Testbench top for http_json_string_pair_scanner_core: drives status lines and
// JSON objects with random gaps and stalls, checks every result in order.
// Depends on hjsps_pkg and hjsps_tb_pkg.
module tb;
    import hjsps_pkg::*;
    import hjsps_tb_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [7:0]          data_byte;
    logic                out_valid;
    logic                out_ready;
    logic [EVENT_W-1:0]  event_res;
    logic [7:0]          char_out;
    logic [5:0]          char_position;
    logic [PHASE_W-1:0]  parse_phase;
    logic [STATUS_W-1:0] status_code;

    pair_scan_tracker trk = new();
    int               sent = 0;
    bit               held_off = 1'b0;

    http_json_string_pair_scanner_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .char_out      (char_out),
        .char_position (char_position),
        .parse_phase   (parse_phase),
        .status_code   (status_code)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                trk.compare_event(event_res, char_out, char_position, parse_phase, status_code);
            if (in_valid && in_ready)
                trk.absorb_byte(command, data_byte);
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sent >= 450 && sent < 600)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic bit is_separator(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF || b == CH_COLON;
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input bit cmd, input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = cmd;
        data_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(1'b0, s[i]);
    endtask

    task automatic send_quoted(input int len);
        send_byte(1'b0, CH_QUOTE);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(1'b0, CH_BSLASH);
                send_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            else
                send_byte(1'b0, plain_byte());
        end
        send_byte(1'b0, CH_QUOTE);
    endtask

    function automatic int string_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 8);
        if (r < 95)
            return $urandom_range(55, 70);
        return $urandom_range(62, 64);
    endfunction

    task automatic send_separators();
        logic [7:0] seps[5];
        int         n;
        seps = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COLON};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_byte(1'b0, seps[$urandom_range(0, 4)]);
    endtask

    task automatic send_status_line();
        int         n;
        logic [7:0] b;
        send_byte(1'b1, 8'($urandom_range(0, 255)));
        repeat (int'(STATUS_SKIP)) send_byte(1'b0, 8'($urandom_range(0, 255)));
        n = $urandom_range(0, 5);
        repeat (n) send_byte(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
        do
            b = 8'($urandom_range(0, 255));
        while (b >= CH_ZERO && b <= CH_NINE);
        send_byte(1'b0, b);
    endtask

    task automatic send_object();
        int         npairs;
        logic [7:0] b;
        repeat ($urandom_range(0, 3))
            send_byte($urandom_range(0, 49) == 0, 8'($urandom_range(0, 255)));
        send_byte(1'b0, CH_LBRACE);
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_byte(1'b0, CH_SPACE);
            send_quoted(string_len());
            send_separators();
            if ($urandom_range(0, 99) < 85)
                send_quoted(string_len());
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || is_separator(b));
                send_byte(1'b0, b);
                repeat ($urandom_range(0, 3)) send_byte(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if (p < npairs - 1)
                send_text(", ");
        end
        send_text("}");
    endtask

    initial
    begin
        int r;
        in_valid  = 1'b0;
        command   = 1'b0;
        data_byte = 8'h00;
        rst_n     = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // restart, saturating status, escaped-quote key, pair done, byte after pair
        send_byte(1'b1, 8'hFF);
        send_text("HTTP/1.1 ");
        send_text("9999x");
        send_text("{\"\\\"\":\"v\"q");

        while (sent < 1000)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                repeat ($urandom_range(5, 20))
                    send_byte($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)));
            end
            else
            begin
                if (r < 75)
                    send_status_line();
                send_object();
            end
        end
        in_valid = 1'b0;

        while (trk.expected_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d bytes, %0d results checked, %0d restarts, %0d status lines",
                 sent, trk.checked, trk.restarts, trk.status_lines);
        $display("tb: %0d pairs completed, %0d truncated strings",
                 trk.pairs_done, trk.truncations);
        if (trk.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && sent >= 250)
            begin
                // hold off long enough to back up the pipeline into the input
                out_ready = 1'b0;
                repeat (150) @(negedge clk);
                held_off = 1'b1;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                out_ready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

@@ http_json_string_pair_scanner_core.f @@
rtl/hjsps_pkg.sv
rtl/http_json_string_pair_scanner_core.sv
verif/hjsps_tb_pkg.sv
verif/tb.sv
